FILE: hdl/iopt_pkg.sv
// shared types and codes for the i/o port permission table
package iopt_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int COUNT_W     = 9;
  localparam int PORT_W      = 16;

  typedef enum logic [1:0] {
    ACT_SET       = 2'd0,
    ACT_CLEAR     = 2'd1,
    ACT_GET       = 2'd2,
    ACT_CLEAR_ALL = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [PORT_W-1:0] port;
  } entry_t;

  typedef struct packed {
    logic load_req;
    logic scan_en;
    logic last_rd;
    logic commit;
    logic found;
  } ctrl_cmd_t;

  typedef struct packed {
    action_t in_action;
    action_t action;
    logic    hit;
    logic    scan_done;
    logic    out_free;
  } dp_stat_t;

endpackage

FILE: hdl/io_port_permission_table_top.sv
// top level of the i/o port permission table
// The table holds up to TABLE_DEPTH entries of a 16-bit port with read and
// write permission bits in a single-port-read memory. Set, clear and get
// walk the valid entries in order, one memory read per cycle, and stop at
// the first match; clear then also fetches the last entry to fill the
// hole, a miss walks all entry_count entries, and clear-all skips the walk.
// One request is worked at a time; the next is accepted as soon as the
// previous result sits in the output register, even while it is stalled.
// No clearing pass after reset: the count alone says which entries are valid.
module io_port_permission_table_top #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // action[1:0], port[17:2], read_perm[18], write_perm[19], zero pad
  input  logic [iopt_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status[1:0], read_allowed[2], write_allowed[3], entry_count[12:4], zero pad
  output logic [iopt_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import iopt_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  iopt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  iopt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

FILE: hdl/iopt_ctrl.sv
// request sequencer: accept, table walk, last-entry fetch, commit
module iopt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  iopt_pkg::dp_stat_t    stat,
  output iopt_pkg::ctrl_cmd_t   cmd
);
  import iopt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   found_r, found_nxt;

  always_comb begin
    state_nxt = state_r;
    found_nxt = found_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          found_nxt    = 1'b0;
          state_nxt    = (stat.in_action == ACT_CLEAR_ALL) ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.hit) begin
          found_nxt = 1'b1;
          state_nxt = (stat.action == ACT_CLEAR) ? ST_LAST : ST_COMMIT;
        end else if (stat.scan_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_LAST: begin
        cmd.last_rd = 1'b1;
        state_nxt   = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    cmd.found = found_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

FILE: hdl/iopt_dp.sv
// table memory, entry count, walk pointer and result register
module iopt_dp #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [iopt_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [iopt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  iopt_pkg::ctrl_cmd_t                 cmd,
  output iopt_pkg::dp_stat_t                  stat
);
  import iopt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  entry_t mem [TABLE_DEPTH];

  action_t           act_r;
  logic [PORT_W-1:0] port_r;
  logic              rd_r, wr_r;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r;
  logic          rd_vld_r;
  logic [IW-1:0] rd_idx_r;
  logic [IW-1:0] hit_idx_r;
  entry_t        rdata_r;

  logic          hit, re_scan, re;
  logic [CW-1:0] last_idx;
  logic [IW-1:0] ra;

  logic          we;
  logic [IW-1:0] wa;
  entry_t        wd;
  status_t       sts;
  logic          rd_o, wr_o;

  logic               out_tvalid_r;
  status_t            out_sts_r;
  logic               out_rd_r, out_wr_r;
  logic [COUNT_W-1:0] out_cnt_r;

  assign hit      = rd_vld_r && (rdata_r.port == port_r);
  assign re_scan  = cmd.scan_en && (idx_r < cnt_r) && !hit;
  assign re       = re_scan || cmd.last_rd;
  assign last_idx = cnt_r - CW'(1);
  assign ra       = cmd.last_rd ? last_idx[IW-1:0] : idx_r[IW-1:0];

  always_comb begin
    we      = 1'b0;
    wa      = hit_idx_r;
    wd      = '{wr: wr_r, rd: rd_r, port: port_r};
    cnt_nxt = cnt_r;
    sts     = STS_OK;
    rd_o    = 1'b0;
    wr_o    = 1'b0;
    if (cmd.commit) begin
      unique case (act_r)
        ACT_SET: begin
          if (cmd.found) begin
            we = 1'b1;
          end else if (cnt_r >= DEPTH_C) begin
            sts = STS_FULL;
          end else begin
            we      = 1'b1;
            wa      = cnt_r[IW-1:0];
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        ACT_CLEAR: begin
          if (cmd.found) begin
            we      = 1'b1;
            wd      = rdata_r;
            cnt_nxt = last_idx;
          end else begin
            sts = STS_NOT_FOUND;
          end
        end
        ACT_GET: begin
          if (cmd.found) begin
            rd_o = rdata_r.rd;
            wr_o = rdata_r.wr;
          end else begin
            sts = STS_NOT_FOUND;
          end
        end
        ACT_CLEAR_ALL: cnt_nxt = '0;
        default: cnt_nxt = cnt_r;
      endcase
    end
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      act_r  <= action_t'(in_tdata[1:0]);
      port_r <= in_tdata[17:2];
      rd_r   <= in_tdata[18];
      wr_r   <= in_tdata[19];
    end
    if (re) begin
      rd_idx_r <= ra;
    end
    if (cmd.scan_en && hit) begin
      hit_idx_r <= rd_idx_r;
    end
    if (cmd.commit) begin
      out_sts_r <= sts;
      out_rd_r  <= rd_o;
      out_wr_r  <= wr_o;
      out_cnt_r <= COUNT_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      idx_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.load_req) begin
        idx_r    <= '0;
        rd_vld_r <= 1'b0;
      end else begin
        rd_vld_r <= re_scan;
        if (re_scan) begin
          idx_r <= idx_r + CW'(1);
        end
      end
      if (cmd.commit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign stat.in_action = action_t'(in_tdata[1:0]);
  assign stat.action    = act_r;
  assign stat.hit       = hit;
  assign stat.scan_done = !rd_vld_r && (idx_r >= cnt_r);
  assign stat.out_free  = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_wr_r, out_rd_r, out_sts_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count above table depth");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_tvalid_r || out_tready))
    else $error("commit while result register occupied");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid_r)
    else $error("commit without result word");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(cnt_r))
    else $error("entry count changed outside commit");

  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_en && hit) |-> (CW'(rd_idx_r) < cnt_r))
    else $error("match on an entry beyond the count");

endmodule
